// ===== design/jmsp_pkg.sv =====
// jmsp_pkg: shared constants for the jpeg marker segment parser
// no dependencies
package jmsp_pkg;
  localparam logic [4:0] PH_WAIT    = 5'd0;
  localparam logic [4:0] PH_MARKS   = 5'd1;
  localparam logic [4:0] PH_ENTROPY = 5'd2;
  localparam logic [4:0] PH_DONE    = 5'd3;
  localparam logic [4:0] PH_HALT    = 5'd4;
  localparam logic [4:0] PH_SEG     = 5'd8;

  localparam logic [2:0] K_FRAME = 3'd0;
  localparam logic [2:0] K_DQT   = 3'd1;
  localparam logic [2:0] K_DHT   = 3'd2;
  localparam logic [2:0] K_DRI   = 3'd3;
  localparam logic [2:0] K_SOS   = 3'd4;
  localparam logic [2:0] K_OTHER = 3'd5;

  localparam logic [3:0] EV_SOI     = 4'd0;
  localparam logic [3:0] EV_FRAME   = 4'd1;
  localparam logic [3:0] EV_QUANT   = 4'd2;
  localparam logic [3:0] EV_HCOUNT  = 4'd3;
  localparam logic [3:0] EV_HSYM    = 4'd4;
  localparam logic [3:0] EV_RESTART = 4'd5;
  localparam logic [3:0] EV_SCAN    = 4'd6;
  localparam logic [3:0] EV_ENTROPY = 4'd7;
  localparam logic [3:0] EV_END     = 4'd8;
  localparam logic [3:0] EV_ERROR   = 4'd9;

  localparam logic [15:0] ERR_NO_SOI    = 16'd0;
  localparam logic [15:0] ERR_PROG      = 16'd1;
  localparam logic [15:0] ERR_COMPS     = 16'd2;
  localparam logic [15:0] ERR_TABLE     = 16'd3;
  localparam logic [15:0] ERR_TRUNCATED = 16'd4;

  localparam logic [7:0] M_SOI  = 8'hD8;
  localparam logic [7:0] M_EOI  = 8'hD9;
  localparam logic [7:0] M_SOF0 = 8'hC0;
  localparam logic [7:0] M_SOF2 = 8'hC2;
  localparam logic [7:0] M_DQT  = 8'hDB;
  localparam logic [7:0] M_DHT  = 8'hC4;
  localparam logic [7:0] M_DRI  = 8'hDD;
  localparam logic [7:0] M_SOS  = 8'hDA;
  localparam logic [7:0] M_RST0 = 8'hD0;
  localparam logic [7:0] M_RST7 = 8'hD7;
  localparam logic [7:0] M_TEM  = 8'h01;

  localparam logic [8:0] QT_BYTES = 9'd65;
  localparam logic [8:0] MAX_SYMBOLS = 9'd256;
  localparam logic [8:0] POS_MAX = 9'd511;

  typedef struct packed {
    logic [3:0]  ev;
    logic [1:0]  tab;
    logic [7:0]  idx;
    logic [15:0] val;
  } result_t;
endpackage

// ===== design/jpeg_marker_segment_parser_top.sv =====
// jpeg_marker_segment_parser_top: byte-serial jpeg marker and segment parser
// depends on jmsp_pkg
//
// takes one file byte per transfer and answers with zero, one or two result
// transfers. the byte is decoded against the parser state in one pass of
// logic and its results land in a four-entry output queue. a byte is taken
// whenever the queue has room for the two results a byte may cause, so the
// block takes one byte per clock whenever that room is there; a byte with
// two results drains while later bytes keep entering as long as room remains.
// segments other than sof0, dqt, dht, dri and sos are skipped by their
// length; run_end marks the last result caused by one byte.
module jpeg_marker_segment_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_res,
  output logic [1:0]  table_number,
  output logic [7:0]  entry_index,
  output logic [15:0] value,
  output logic        run_end
);

  // parser state
  logic [4:0]  parse_phase, parse_phase_next;
  logic        held_ff, held_ff_next;
  logic [15:0] segment_remaining, segment_remaining_next;
  logic [8:0]  field_position, field_position_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [1:0]  current_table, current_table_next;
  logic [8:0]  symbol_total, symbol_total_next;
  logic [1:0]  component_count, component_count_next;
  logic [15:0] restart_interval, restart_interval_next;
  logic        thumbnail_skip, thumbnail_skip_next;
  logic        error_hold, error_hold_next;

  // results of the current byte
  jmsp_pkg::result_t res [2];
  logic [1:0] res_n;

  // output queue: up to four entries, each result plus its run_end flag
  logic [30:0] q_mem [4];
  logic [1:0]  q_rd, q_wr;
  logic [2:0]  q_cnt;

  logic in_fire, out_fire;
  assign in_stall = (q_cnt > 3'd2);
  assign in_fire = in_valid && !in_stall;
  assign out_valid = (q_cnt != 3'd0);
  assign out_fire = out_valid && !out_stall;
  assign {event_res, table_number, entry_index, value, run_end} = q_mem[q_rd];

  always_comb begin
    logic [7:0]  b;
    logic [4:0]  ph;
    logic [2:0]  kind;
    logic [1:0]  sub;
    logic [8:0]  pos, nxt;
    logic [15:0] len;
    logic [9:0]  sum;
    logic        do_disp;
    logic [7:0]  m;

    b = data_byte;
    ph = parse_phase;
    kind = 3'd0;
    sub = 2'd0;
    pos = field_position;
    nxt = 9'd0;
    len = 16'd0;
    sum = 10'd0;
    do_disp = 1'b0;
    m = b;
    parse_phase_next = parse_phase;
    held_ff_next = held_ff;
    segment_remaining_next = segment_remaining;
    field_position_next = field_position;
    high_byte_next = high_byte;
    current_table_next = current_table;
    symbol_total_next = symbol_total;
    component_count_next = component_count;
    restart_interval_next = restart_interval;
    thumbnail_skip_next = thumbnail_skip;
    error_hold_next = error_hold;
    res[0] = '0;
    res[1] = '0;
    res_n = 2'd0;

    if (ph == jmsp_pkg::PH_WAIT || ph == jmsp_pkg::PH_MARKS) begin
      if (held_ff) begin
        if (b == 8'h00) begin
          held_ff_next = 1'b0;
        end else if (b != 8'hFF) begin
          held_ff_next = 1'b0;
          if (ph == jmsp_pkg::PH_WAIT) begin
            if (b == jmsp_pkg::M_SOI) begin
              res[0] = '{jmsp_pkg::EV_SOI, 2'd0, 8'd0, 16'd0};
              res_n = 2'd1;
              parse_phase_next = jmsp_pkg::PH_MARKS;
            end else begin
              res[0] = '{jmsp_pkg::EV_ERROR, 2'd0, 8'd0, jmsp_pkg::ERR_NO_SOI};
              res_n = 2'd1;
              error_hold_next = 1'b1;
              parse_phase_next = jmsp_pkg::PH_HALT;
            end
          end else if (thumbnail_skip) begin
            if (b == jmsp_pkg::M_EOI) thumbnail_skip_next = 1'b0;
          end else begin
            do_disp = 1'b1;
          end
        end
      end else if (b == 8'hFF) begin
        held_ff_next = 1'b1;
      end
    end else if (ph == jmsp_pkg::PH_ENTROPY) begin
      if (held_ff) begin
        if (b == 8'h00) begin
          held_ff_next = 1'b0;
          res[0] = '{jmsp_pkg::EV_ENTROPY, 2'd0, 8'd0, 16'h00FF};
          res_n = 2'd1;
        end else if (b == 8'hFF) begin
          // fill byte dropped
        end else if (b >= jmsp_pkg::M_RST0 && b <= jmsp_pkg::M_RST7
                     && restart_interval != 16'd0) begin
          held_ff_next = 1'b0;
          res[0] = '{jmsp_pkg::EV_RESTART, 2'd0, 8'd1, {13'd0, b[2:0]}};
          res_n = 2'd1;
        end else begin
          do_disp = 1'b1;
        end
      end else if (b == 8'hFF) begin
        held_ff_next = 1'b1;
      end else begin
        res[0] = '{jmsp_pkg::EV_ENTROPY, 2'd0, 8'd0, {8'd0, b}};
        res_n = 2'd1;
      end
    end else if (ph >= jmsp_pkg::PH_SEG) begin
      kind = 3'((ph - jmsp_pkg::PH_SEG) >> 2);
      sub = ph[1:0];
      if (kind <= jmsp_pkg::K_OTHER) begin
        if (sub == 2'd0) begin
          high_byte_next = b;
          parse_phase_next = ph + 5'd1;
        end else if (sub == 2'd1) begin
          len = {high_byte, b};
          segment_remaining_next = (len >= 16'd2) ? len - 16'd2 : 16'd0;
          field_position_next = 9'd0;
          symbol_total_next = 9'd0;
          parse_phase_next = ph + 5'd1;
          if (len < 16'd3) begin
            held_ff_next = 1'b0;
            parse_phase_next = (kind == jmsp_pkg::K_SOS) ? jmsp_pkg::PH_ENTROPY
                                                        : jmsp_pkg::PH_MARKS;
          end
        end else if (sub == 2'd2) begin
          nxt = (pos < jmsp_pkg::POS_MAX) ? pos + 9'd1 : jmsp_pkg::POS_MAX;
          segment_remaining_next = segment_remaining - 16'd1;
          case (kind)
            jmsp_pkg::K_FRAME: begin
              if (pos == 9'd0) begin
                res[0] = '{jmsp_pkg::EV_FRAME, 2'd0, 8'd0, {8'd0, b}};
                res_n = 2'd1;
              end else if (pos == 9'd1 || pos == 9'd3) begin
                high_byte_next = b;
              end else if (pos == 9'd2 || pos == 9'd4) begin
                res[0] = '{jmsp_pkg::EV_FRAME, 2'd0, {6'd0, pos[2:1]}, {high_byte, b}};
                res_n = 2'd1;
              end else if (pos == 9'd5) begin
                res[0] = '{jmsp_pkg::EV_FRAME, 2'd0, 8'd3, {8'd0, b}};
                res_n = 2'd1;
                if (b != 8'd3) begin
                  res[1] = '{jmsp_pkg::EV_ERROR, 2'd0, 8'd0, jmsp_pkg::ERR_COMPS};
                  res_n = 2'd2;
                  error_hold_next = 1'b1;
                end else begin
                  component_count_next = 2'd3;
                end
              end else if (pos <= 9'd14) begin
                res[0] = '{jmsp_pkg::EV_FRAME, 2'd0, 8'(pos - 9'd2), {8'd0, b}};
                res_n = 2'd1;
              end
            end
            jmsp_pkg::K_DQT: begin
              if (pos == 9'd0) begin
                if (b[3:0] > 4'd3) begin
                  res[0] = '{jmsp_pkg::EV_ERROR, 2'd0, 8'd0, jmsp_pkg::ERR_TABLE};
                  res_n = 2'd1;
                  error_hold_next = 1'b1;
                end else begin
                  current_table_next = b[1:0];
                end
                nxt = 9'd1;
              end else begin
                res[0] = '{jmsp_pkg::EV_QUANT, current_table, 8'(pos - 9'd1), {8'd0, b}};
                res_n = 2'd1;
                nxt = (pos >= jmsp_pkg::QT_BYTES - 9'd1) ? 9'd0 : pos + 9'd1;
              end
            end
            jmsp_pkg::K_DHT: begin
              if (pos == 9'd0) begin
                if (b[7:4] > 4'd1 || b[3:0] > 4'd1) begin
                  res[0] = '{jmsp_pkg::EV_ERROR, 2'd0, 8'd0, jmsp_pkg::ERR_TABLE};
                  res_n = 2'd1;
                  error_hold_next = 1'b1;
                end else begin
                  current_table_next = {b[4], b[0]};
                end
                symbol_total_next = 9'd0;
                nxt = 9'd1;
              end else if (pos <= 9'd16) begin
                res[0] = '{jmsp_pkg::EV_HCOUNT, current_table, 8'(pos - 9'd1), {8'd0, b}};
                res_n = 2'd1;
                sum = {1'b0, symbol_total} + {2'd0, b};
                symbol_total_next = (sum > 10'(jmsp_pkg::MAX_SYMBOLS))
                                    ? jmsp_pkg::MAX_SYMBOLS : sum[8:0];
                nxt = (pos < 9'd16) ? pos + 9'd1
                      : ((symbol_total_next != 9'd0) ? 9'd17 : 9'd0);
              end else begin
                res[0] = '{jmsp_pkg::EV_HSYM, current_table, 8'(pos - 9'd17), {8'd0, b}};
                res_n = 2'd1;
                symbol_total_next = (symbol_total != 9'd0) ? symbol_total - 9'd1 : 9'd0;
                nxt = (symbol_total_next != 9'd0) ? pos + 9'd1 : 9'd0;
              end
            end
            jmsp_pkg::K_DRI: begin
              if (pos == 9'd0) begin
                high_byte_next = b;
              end else if (pos == 9'd1) begin
                restart_interval_next = {high_byte, b};
                res[0] = '{jmsp_pkg::EV_RESTART, 2'd0, 8'd0, {high_byte, b}};
                res_n = 2'd1;
              end
            end
            jmsp_pkg::K_SOS: begin
              res[0] = '{jmsp_pkg::EV_SCAN, 2'd0,
                         (pos > 9'd255) ? 8'd255 : pos[7:0], {8'd0, b}};
              res_n = 2'd1;
            end
            default: begin
            end
          endcase
          if (error_hold_next) begin
            parse_phase_next = jmsp_pkg::PH_HALT;
          end else begin
            field_position_next = nxt;
            if (segment_remaining_next == 16'd0) begin
              held_ff_next = 1'b0;
              parse_phase_next = (kind == jmsp_pkg::K_SOS) ? jmsp_pkg::PH_ENTROPY
                                                          : jmsp_pkg::PH_MARKS;
            end
          end
        end
      end
    end

    // marker dispatch, shared by marker scanning and entropy data
    if (do_disp) begin
      held_ff_next = 1'b0;
      if (m == jmsp_pkg::M_SOI) begin
        thumbnail_skip_next = 1'b1;
        parse_phase_next = jmsp_pkg::PH_MARKS;
      end else if (m == jmsp_pkg::M_EOI) begin
        res[0] = '{jmsp_pkg::EV_END, 2'd0, 8'd0, 16'd0};
        res_n = 2'd1;
        parse_phase_next = jmsp_pkg::PH_DONE;
      end else if (m == jmsp_pkg::M_SOF2) begin
        res[0] = '{jmsp_pkg::EV_ERROR, 2'd0, 8'd0, jmsp_pkg::ERR_PROG};
        res_n = 2'd1;
        error_hold_next = 1'b1;
        parse_phase_next = jmsp_pkg::PH_HALT;
      end else if (m == jmsp_pkg::M_SOF0) begin
        parse_phase_next = jmsp_pkg::PH_SEG + {jmsp_pkg::K_FRAME, 2'b00};
      end else if (m == jmsp_pkg::M_DQT) begin
        parse_phase_next = jmsp_pkg::PH_SEG + {jmsp_pkg::K_DQT, 2'b00};
      end else if (m == jmsp_pkg::M_DHT) begin
        parse_phase_next = jmsp_pkg::PH_SEG + {jmsp_pkg::K_DHT, 2'b00};
      end else if (m == jmsp_pkg::M_DRI) begin
        parse_phase_next = jmsp_pkg::PH_SEG + {jmsp_pkg::K_DRI, 2'b00};
      end else if (m == jmsp_pkg::M_SOS) begin
        parse_phase_next = jmsp_pkg::PH_SEG + {jmsp_pkg::K_SOS, 2'b00};
      end else if ((m >= jmsp_pkg::M_RST0 && m <= jmsp_pkg::M_RST7)
                   || m == jmsp_pkg::M_TEM) begin
        parse_phase_next = jmsp_pkg::PH_MARKS;
      end else begin
        parse_phase_next = jmsp_pkg::PH_SEG + {jmsp_pkg::K_OTHER, 2'b00};
      end
    end

    // last byte of the file: closing result if due, then back to reset state
    if (final_byte) begin
      if (parse_phase_next != jmsp_pkg::PH_DONE && parse_phase_next != jmsp_pkg::PH_HALT
          && !error_hold_next && res_n != 2'd2) begin
        if (parse_phase_next >= jmsp_pkg::PH_SEG)
          res[res_n[0]] = '{jmsp_pkg::EV_ERROR, 2'd0, 8'd0, jmsp_pkg::ERR_TRUNCATED};
        else if (parse_phase_next == jmsp_pkg::PH_WAIT)
          res[res_n[0]] = '{jmsp_pkg::EV_ERROR, 2'd0, 8'd0, jmsp_pkg::ERR_NO_SOI};
        else
          res[res_n[0]] = '{jmsp_pkg::EV_END, 2'd0, 8'd0, 16'd0};
        res_n = res_n + 2'd1;
      end
      parse_phase_next = jmsp_pkg::PH_WAIT;
      held_ff_next = 1'b0;
      segment_remaining_next = 16'd0;
      field_position_next = 9'd0;
      high_byte_next = 8'd0;
      current_table_next = 2'd0;
      symbol_total_next = 9'd0;
      component_count_next = 2'd0;
      restart_interval_next = 16'd0;
      thumbnail_skip_next = 1'b0;
      error_hold_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= jmsp_pkg::PH_WAIT;
      held_ff <= 1'b0;
      segment_remaining <= 16'd0;
      field_position <= 9'd0;
      high_byte <= 8'd0;
      current_table <= 2'd0;
      symbol_total <= 9'd0;
      component_count <= 2'd0;
      restart_interval <= 16'd0;
      thumbnail_skip <= 1'b0;
      error_hold <= 1'b0;
    end else if (in_fire) begin
      parse_phase <= parse_phase_next;
      held_ff <= held_ff_next;
      segment_remaining <= segment_remaining_next;
      field_position <= field_position_next;
      high_byte <= high_byte_next;
      current_table <= current_table_next;
      symbol_total <= symbol_total_next;
      component_count <= component_count_next;
      restart_interval <= restart_interval_next;
      thumbnail_skip <= thumbnail_skip_next;
      error_hold <= error_hold_next;
    end
  end

  // queue write: results of the accepted byte, run_end on the last
  logic [1:0] wr_n;
  assign wr_n = in_fire ? res_n : 2'd0;

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0)
      q_mem[q_wr] <= {res[0], (res_n == 2'd1)};
    if (wr_n == 2'd2)
      q_mem[q_wr + 2'd1] <= {res[1], 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd <= 2'd0;
      q_wr <= 2'd0;
      q_cnt <= 3'd0;
    end else begin
      q_wr <= q_wr + wr_n;
      q_rd <= q_rd + {1'b0, out_fire};
      q_cnt <= q_cnt + {1'b0, wr_n} - {2'd0, out_fire};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= 3'd4) else $error("output queue overflow");
  a_hold_reset: assert property (@(posedge clk) disable iff (rst)
    (in_fire && final_byte) |=> (parse_phase == jmsp_pkg::PH_WAIT && !error_hold))
    else $error("state not cleared after last byte");
  a_halt_err: assert property (@(posedge clk) disable iff (rst)
    error_hold |-> parse_phase == jmsp_pkg::PH_HALT) else $error("error without halt");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped while stalled");
`endif
endmodule

// ===== dv/jpeg_marker_segment_parser_top_tb.sv =====
// jpeg_marker_segment_parser_top_tb: self-checking testbench for the jpeg parser
// depends on jmsp_pkg and jpeg_marker_segment_parser_top
// feeds directed and random jpeg byte streams, predicts every event, checks in order
module jpeg_marker_segment_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]  ev;
    logic [1:0]  tab;
    logic [7:0]  idx;
    logic [15:0] val;
    logic        last;
  } jpeg_event_t;

  // scoreboard: mirrors the parser state and keeps the events still owed
  class jpeg_event_scoreboard;
    jpeg_event_t owed[$];
    jpeg_event_t step_q[$];
    int          errors;
    logic [4:0]  phase;
    logic        ff_seen;
    logic [15:0] seg_left;
    logic [8:0]  field_pos;
    logic [7:0]  hi_byte;
    logic [1:0]  cur_tab;
    int          sym_left;
    logic [15:0] rst_interval;
    logic        thumb_skip;
    logic        halted;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = jmsp_pkg::PH_WAIT; ff_seen = 0; seg_left = 0; field_pos = 0; hi_byte = 0;
      cur_tab = 0; sym_left = 0; rst_interval = 0; thumb_skip = 0; halted = 0;
    endfunction

    function void put(logic [3:0] ev, logic [1:0] tab, logic [7:0] idx, logic [15:0] val);
      jpeg_event_t e;
      e.ev = ev; e.tab = tab; e.idx = idx; e.val = val; e.last = 0;
      if (step_q.size() < 2) step_q.push_back(e);
    endfunction

    function void flag(logic [15:0] code);
      put(jmsp_pkg::EV_ERROR, 0, 0, code);
      halted = 1;
      phase = jmsp_pkg::PH_HALT;
    endfunction

    function void open_seg(logic [2:0] kind);
      ff_seen = 0;
      phase = jmsp_pkg::PH_SEG + {kind, 2'b00};
    endfunction

    function void close_seg(logic [2:0] kind);
      ff_seen = 0;
      phase = (kind == jmsp_pkg::K_SOS) ? jmsp_pkg::PH_ENTROPY : jmsp_pkg::PH_MARKS;
    endfunction

    function void on_marker(logic [7:0] m);
      ff_seen = 0;
      if (m == jmsp_pkg::M_SOI) begin
        thumb_skip = 1; phase = jmsp_pkg::PH_MARKS;
      end else if (m == jmsp_pkg::M_EOI) begin
        put(jmsp_pkg::EV_END, 0, 0, 0); phase = jmsp_pkg::PH_DONE;
      end else if (m == jmsp_pkg::M_SOF2) flag(jmsp_pkg::ERR_PROG);
      else if (m == jmsp_pkg::M_SOF0) open_seg(jmsp_pkg::K_FRAME);
      else if (m == jmsp_pkg::M_DQT) open_seg(jmsp_pkg::K_DQT);
      else if (m == jmsp_pkg::M_DHT) open_seg(jmsp_pkg::K_DHT);
      else if (m == jmsp_pkg::M_DRI) open_seg(jmsp_pkg::K_DRI);
      else if (m == jmsp_pkg::M_SOS) open_seg(jmsp_pkg::K_SOS);
      else if ((m >= jmsp_pkg::M_RST0 && m <= jmsp_pkg::M_RST7) || m == jmsp_pkg::M_TEM)
        phase = jmsp_pkg::PH_MARKS;
      else open_seg(jmsp_pkg::K_OTHER);
    endfunction

    function void segment_body(logic [2:0] kind, logic [7:0] b);
      logic [8:0] pos;
      logic [8:0] nxt;
      pos = field_pos;
      nxt = (pos < jmsp_pkg::POS_MAX) ? pos + 9'd1 : jmsp_pkg::POS_MAX;
      seg_left = seg_left - 16'd1;
      case (kind)
        jmsp_pkg::K_FRAME: begin
          if (pos == 0) put(jmsp_pkg::EV_FRAME, 0, 0, {8'd0, b});
          else if (pos == 1 || pos == 3) hi_byte = b;
          else if (pos == 2 || pos == 4)
            put(jmsp_pkg::EV_FRAME, 0, 8'(pos / 2), {hi_byte, b});
          else if (pos == 5) begin
            put(jmsp_pkg::EV_FRAME, 0, 3, {8'd0, b});
            if (b != 8'd3) flag(jmsp_pkg::ERR_COMPS);
          end else if (pos <= 14) put(jmsp_pkg::EV_FRAME, 0, 8'(pos - 2), {8'd0, b});
        end
        jmsp_pkg::K_DQT: begin
          if (pos == 0) begin
            if (b[3:0] > 3) flag(jmsp_pkg::ERR_TABLE); else cur_tab = b[1:0];
            nxt = 1;
          end else begin
            put(jmsp_pkg::EV_QUANT, cur_tab, 8'(pos - 1), {8'd0, b});
            nxt = (pos >= jmsp_pkg::QT_BYTES - 1) ? 9'd0 : pos + 9'd1;
          end
        end
        jmsp_pkg::K_DHT: begin
          if (pos == 0) begin
            if (b[7:4] > 1 || b[3:0] > 1) flag(jmsp_pkg::ERR_TABLE);
            else cur_tab = {b[4], b[0]};
            sym_left = 0;
            nxt = 1;
          end else if (pos <= 16) begin
            put(jmsp_pkg::EV_HCOUNT, cur_tab, 8'(pos - 1), {8'd0, b});
            sym_left += b;
            if (sym_left > jmsp_pkg::MAX_SYMBOLS) sym_left = jmsp_pkg::MAX_SYMBOLS;
            nxt = (pos < 16) ? pos + 9'd1 : (sym_left != 0 ? 9'd17 : 9'd0);
          end else begin
            put(jmsp_pkg::EV_HSYM, cur_tab, 8'(pos - 17), {8'd0, b});
            if (sym_left != 0) sym_left--;
            nxt = (sym_left != 0) ? pos + 9'd1 : 9'd0;
          end
        end
        jmsp_pkg::K_DRI: begin
          if (pos == 0) hi_byte = b;
          else if (pos == 1) begin
            rst_interval = {hi_byte, b};
            put(jmsp_pkg::EV_RESTART, 0, 0, rst_interval);
          end
        end
        jmsp_pkg::K_SOS:
          put(jmsp_pkg::EV_SCAN, 0, (pos > 255) ? 8'd255 : pos[7:0], {8'd0, b});
        default: ;
      endcase
      if (!halted) begin
        field_pos = nxt;
        if (seg_left == 0) close_seg(kind);
      end
    endfunction

    // one accepted byte: work out the events it owes
    function void note_byte(logic [7:0] b, logic fin);
      logic [4:0] ph;
      logic [2:0] kind;
      logic [1:0] sub;
      logic [15:0] len;
      step_q.delete();
      ph = phase;
      if (ph == jmsp_pkg::PH_WAIT || ph == jmsp_pkg::PH_MARKS) begin
        if (ff_seen) begin
          if (b == 8'h00) ff_seen = 0;
          else if (b != 8'hFF) begin
            ff_seen = 0;
            if (ph == jmsp_pkg::PH_WAIT) begin
              if (b == jmsp_pkg::M_SOI) begin
                put(jmsp_pkg::EV_SOI, 0, 0, 0); phase = jmsp_pkg::PH_MARKS;
              end else flag(jmsp_pkg::ERR_NO_SOI);
            end else if (thumb_skip) begin
              if (b == jmsp_pkg::M_EOI) thumb_skip = 0;
            end else on_marker(b);
          end
        end else if (b == 8'hFF) ff_seen = 1;
      end else if (ph == jmsp_pkg::PH_ENTROPY) begin
        if (ff_seen) begin
          if (b == 8'h00) begin
            ff_seen = 0; put(jmsp_pkg::EV_ENTROPY, 0, 0, 16'hFF);
          end else if (b == 8'hFF) begin
          end else if (b >= jmsp_pkg::M_RST0 && b <= jmsp_pkg::M_RST7
                       && rst_interval != 0) begin
            ff_seen = 0; put(jmsp_pkg::EV_RESTART, 0, 1, {13'd0, b[2:0]});
          end else on_marker(b);
        end else if (b == 8'hFF) ff_seen = 1;
        else put(jmsp_pkg::EV_ENTROPY, 0, 0, {8'd0, b});
      end else if (ph >= jmsp_pkg::PH_SEG) begin
        kind = 3'((ph - jmsp_pkg::PH_SEG) >> 2);
        sub = ph[1:0];
        if (sub == 0) begin
          hi_byte = b; phase = ph + 5'd1;
        end else if (sub == 1) begin
          len = {hi_byte, b};
          seg_left = (len >= 2) ? len - 16'd2 : 16'd0;
          field_pos = 0; sym_left = 0; phase = ph + 5'd1;
          if (seg_left == 0) close_seg(kind);
        end else if (sub == 2) segment_body(kind, b);
      end
      if (fin) begin
        ph = phase;
        if (ph != jmsp_pkg::PH_DONE && ph != jmsp_pkg::PH_HALT && !halted) begin
          if (ph >= jmsp_pkg::PH_SEG) put(jmsp_pkg::EV_ERROR, 0, 0, jmsp_pkg::ERR_TRUNCATED);
          else if (ph == jmsp_pkg::PH_WAIT) put(jmsp_pkg::EV_ERROR, 0, 0, jmsp_pkg::ERR_NO_SOI);
          else put(jmsp_pkg::EV_END, 0, 0, 0);
        end
        clear();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
      foreach (step_q[i]) owed.push_back(step_q[i]);
    endfunction

    function void check_event(logic [3:0] ev, logic [1:0] tab, logic [7:0] idx,
                              logic [15:0] val, logic last);
      jpeg_event_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected event ev=%0d idx=%0d val=%h", $realtime, ev, idx, val);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (ev !== e.ev) begin
        $display("%0t: event_res expected %0d actual %0d", $realtime, e.ev, ev); errors++;
      end
      if (tab !== e.tab) begin
        $display("%0t: table_number expected %0d actual %0d", $realtime, e.tab, tab); errors++;
      end
      if (idx !== e.idx) begin
        $display("%0t: entry_index expected %0d actual %0d", $realtime, e.idx, idx); errors++;
      end
      if (val !== e.val) begin
        $display("%0t: value expected %h actual %h", $realtime, e.val, val); errors++;
      end
      if (last !== e.last) begin
        $display("%0t: run_end expected %0b actual %0b", $realtime, e.last, last); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  event_res;
  logic [1:0]  table_number;
  logic [7:0]  entry_index;
  logic [15:0] value;
  logic        run_end;

  jpeg_event_scoreboard sb;
  logic [7:0] file_q[$];   // bytes of the file being built
  bit         calm;        // no idling on either side
  int         bytes_sent;

  jpeg_marker_segment_parser_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .final_byte(final_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .table_number(table_number),
    .entry_index(entry_index), .value(value), .run_end(run_end)
  );

  // 12 ns clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // result side: check every accepted result transfer against the oldest owed event
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_event(event_res, table_number, entry_index, value, run_end);
  end

  // receiver backpressure in random bursts, none once the run goes calm
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // one byte transfer, with an occasional idle burst ahead of it
  task automatic send_byte(logic [7:0] b, logic fin);
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    final_byte = fin;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  // push the built file, marking its last byte
  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  function automatic void push_bytes(logic [7:0] a[]);
    foreach (a[i]) file_q.push_back(a[i]);
  endfunction

  // marker plus length field; the length is usually right, sometimes off
  function automatic void push_seg_head(logic [7:0] m, int body_len);
    int len;
    len = body_len + 2;
    if ($urandom_range(0, 15) == 0) len = $urandom_range(0, body_len + 4);
    push_bytes('{8'hFF, m, len[15:8], len[7:0]});
  endfunction

  function automatic void build_frame();
    int ncomp;
    push_seg_head(jmsp_pkg::M_SOF0, 15);
    ncomp = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : 3;
    push_bytes('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'(ncomp)});
    repeat (9) file_q.push_back(8'($urandom));
  endfunction

  function automatic void build_quant();
    logic [7:0] tb;
    tb = {4'($urandom), 2'b00, 2'($urandom)};
    if ($urandom_range(0, 7) == 0) tb = 8'($urandom);
    push_seg_head(jmsp_pkg::M_DQT, 65);
    file_q.push_back(tb);
    repeat (64) file_q.push_back(8'($urandom));
  endfunction

  function automatic void build_huff();
    logic [7:0] counts[16];
    logic [7:0] tb;
    int total;
    total = 0;
    tb = {3'd0, 1'($urandom), 3'd0, 1'($urandom)};
    if ($urandom_range(0, 7) == 0) tb = 8'($urandom);
    foreach (counts[i]) begin
      counts[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : 8'd0;
      if ($urandom_range(0, 40) == 0) counts[i] = 8'($urandom);
      total += counts[i];
    end
    if (total > 12) total = 12;   // symbol list cut short, length keeps it honest
    push_seg_head(jmsp_pkg::M_DHT, 17 + total);
    file_q.push_back(tb);
    foreach (counts[i]) file_q.push_back(counts[i]);
    repeat (total) file_q.push_back(8'($urandom));
  endfunction

  function automatic void build_entropy(int n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(0, 15))
        0: push_bytes('{8'hFF, 8'h00});
        1: push_bytes('{8'hFF, 8'hFF, 8'(jmsp_pkg::M_RST0 + $urandom_range(0, 7))});
        2: push_bytes('{8'hFF, 8'(jmsp_pkg::M_RST0 + $urandom_range(0, 7))});
        default: begin
          b = 8'($urandom);
          file_q.push_back(b);
          if (b == 8'hFF) file_q.push_back(8'h00);
        end
      endcase
    end
  endfunction

  // a mostly well-formed baseline file with random content and occasional damage
  function automatic void build_file();
    int n;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom));
    push_bytes('{8'hFF, jmsp_pkg::M_SOI});
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(0, 6);
      push_seg_head(8'hE0 + 8'($urandom_range(0, 15)), n);
      repeat (n) file_q.push_back(8'($urandom));
    end
    if ($urandom_range(0, 4) == 0) begin
      push_bytes('{8'hFF, jmsp_pkg::M_SOI, 8'h12, 8'hFF, 8'hC0, 8'h00, 8'hFF,
                   jmsp_pkg::M_EOI});
    end
    if ($urandom_range(0, 3) == 0)
      push_bytes('{8'hFF, 8'hFF, jmsp_pkg::M_TEM, 8'hFF, jmsp_pkg::M_RST7});
    if ($urandom_range(0, 2) == 0) build_quant();
    build_huff();
    if ($urandom_range(0, 1)) begin
      push_seg_head(jmsp_pkg::M_DRI, 2);
      push_bytes('{($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00, 8'($urandom_range(0, 3))});
    end
    if ($urandom_range(0, 11) == 0) push_bytes('{8'hFF, jmsp_pkg::M_SOF2});
    build_frame();
    n = $urandom_range(6, 12);
    push_seg_head(jmsp_pkg::M_SOS, n);
    repeat (n) file_q.push_back(8'($urandom));
    build_entropy($urandom_range(5, 40));
    push_bytes('{8'hFF, jmsp_pkg::M_EOI});
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
    // truncated file now and then
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, file_q.size());
      while (file_q.size() > n) void'(file_q.pop_back());
    end
  endfunction

  initial begin
    int files;
    sb = new();
    calm = 0;
    bytes_sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    final_byte = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: junk and fill before soi, standalone markers, end on eoi
    push_bytes('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, jmsp_pkg::M_SOI, 8'hFF,
                 jmsp_pkg::M_TEM, 8'hFF, jmsp_pkg::M_RST0, 8'hFF, jmsp_pkg::M_EOI});
    send_file();
    // last byte without any soi
    push_bytes('{8'hAB});
    send_file();
    // first marker is not soi
    push_bytes('{8'hFF, jmsp_pkg::M_DHT, 8'h00});
    send_file();
    // progressive frame
    push_bytes('{8'hFF, jmsp_pkg::M_SOI, 8'hFF, jmsp_pkg::M_SOF2, 8'h00});
    send_file();
    // short length, then truncated inside a segment
    push_bytes('{8'hFF, jmsp_pkg::M_SOI, 8'hFF, 8'hE1, 8'h00, 8'h01, 8'hFF,
                 jmsp_pkg::M_DRI, 8'hFF});
    send_file();

    // random files
    files = 0;
    while (bytes_sent < 560) begin
      if (bytes_sent > 470) calm = 1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 20))
          file_q.push_back(($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom));
      end else build_file();
      send_file();
      files++;
      // after the second file, hold the sender until the parser has drained everything owed
      if (files == 2) begin
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.owed.size() != 0) @(posedge clk);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("jpeg_marker_segment_parser_top_tb: PASS");
    end else begin
      $display("jpeg_marker_segment_parser_top_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("jpeg_marker_segment_parser_top_tb: FAIL");
    $finish;
  end
endmodule

// ===== jpeg_marker_segment_parser_top.f =====
design/jmsp_pkg.sv
design/jpeg_marker_segment_parser_top.sv
dv/jpeg_marker_segment_parser_top_tb.sv
